// ===== hw/rtl/slts_pkg.sv =====
package slts_pkg;

  localparam int ROW_W   = 10;
  localparam int VALUE_W = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SCALE,
    ST_SUB,
    ST_DIV_INIT,
    ST_DIV,
    ST_DIV_FIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic scale;
    logic sub;
    logic div_init;
    logic div_step;
    logic div_fin;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic div_last;
    logic out_busy;
  } status_t;

endpackage

// ===== hw/rtl/slts_item_if.sv =====
interface slts_item_if;
  logic                                valid;
  logic                                ready;
  logic        [slts_pkg::ROW_W-1:0]   row;
  logic        [slts_pkg::ROW_W-1:0]   column;
  logic signed [slts_pkg::VALUE_W-1:0] coefficient;
  logic signed [slts_pkg::VALUE_W-1:0] right_side;
  logic                                first_of_row;
  logic                                last_of_row;

  modport source (
    output valid, row, column, coefficient, right_side, first_of_row, last_of_row,
    input  ready
  );
  modport sink (
    input  valid, row, column, coefficient, right_side, first_of_row, last_of_row,
    output ready
  );
endinterface

// ===== hw/rtl/slts_result_if.sv =====
interface slts_result_if;
  logic                                valid;
  logic                                ready;
  logic        [slts_pkg::ROW_W-1:0]   solved_row;
  logic signed [slts_pkg::VALUE_W-1:0] solution;
  logic                                zero_diagonal;
  logic                                saturated;

  modport source (
    output valid, solved_row, solution, zero_diagonal, saturated,
    input  ready
  );
  modport sink (
    input  valid, solved_row, solution, zero_diagonal, saturated,
    output ready
  );
endinterface

// ===== hw/rtl/sparse_lower_triangular_solve.sv =====
// Off-diagonal word: accept, multiply, round, subtract, in that order; store read issued at accept.
// Diagonal word (Q16.16 at the default FRACTION_BITS): accept, divider setup, one-bit-per-cycle divide, finish,
// emit once the output register is free; the result sits in that register, so the next word is taken while it waits.
// One word in flight at a time.
// Synchronous active-high rst clears the controller, accumulator, flag and output valid;
// the solution store is not cleared.
module sparse_lower_triangular_solve #(
  parameter int MAX_ROWS      = 1024,
  parameter int FRACTION_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  slts_item_if.sink     item,
  slts_result_if.source result
);

  slts_pkg::cmd_t    cmd;
  slts_pkg::status_t status;

  slts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (item.ready),
    .status   (status),
    .cmd      (cmd)
  );

  slts_dp #(
    .MAX_ROWS      (MAX_ROWS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .row           (item.row),
    .column        (item.column),
    .coefficient   (item.coefficient),
    .right_side    (item.right_side),
    .first_of_row  (item.first_of_row),
    .last_of_row   (item.last_of_row),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .solved_row    (result.solved_row),
    .solution      (result.solution),
    .zero_diagonal (result.zero_diagonal),
    .saturated     (result.saturated)
  );

endmodule

// ===== hw/rtl/slts_ram.sv =====
module slts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/slts_ctrl.sv =====
module slts_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  slts_pkg::status_t status,
  output slts_pkg::cmd_t    cmd
);

  slts_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= slts_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      slts_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = status.last ? slts_pkg::ST_DIV_INIT : slts_pkg::ST_MUL;
        end
      end
      slts_pkg::ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = slts_pkg::ST_SCALE;
      end
      slts_pkg::ST_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = slts_pkg::ST_SUB;
      end
      slts_pkg::ST_SUB: begin
        cmd.sub    = 1'b1;
        state_next = slts_pkg::ST_IDLE;
      end
      slts_pkg::ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_next   = slts_pkg::ST_DIV;
      end
      slts_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = slts_pkg::ST_DIV_FIN;
        end
      end
      slts_pkg::ST_DIV_FIN: begin
        cmd.div_fin = 1'b1;
        state_next  = slts_pkg::ST_EMIT;
      end
      slts_pkg::ST_EMIT: begin
        if (!status.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = slts_pkg::ST_IDLE;
        end
      end
      default: state_next = slts_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/slts_dp.sv =====
module slts_dp #(
  parameter int MAX_ROWS      = 1024,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  slts_pkg::cmd_t                      cmd,
  output slts_pkg::status_t                   status,
  input  logic        [slts_pkg::ROW_W-1:0]   row,
  input  logic        [slts_pkg::ROW_W-1:0]   column,
  input  logic signed [slts_pkg::VALUE_W-1:0] coefficient,
  input  logic signed [slts_pkg::VALUE_W-1:0] right_side,
  input  logic                                first_of_row,
  input  logic                                last_of_row,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic        [slts_pkg::ROW_W-1:0]   solved_row,
  output logic signed [slts_pkg::VALUE_W-1:0] solution,
  output logic                                zero_diagonal,
  output logic                                saturated
);

  localparam int VW = slts_pkg::VALUE_W;
  localparam int AW = $clog2(MAX_ROWS);
  localparam int DW = VW + FRACTION_BITS;
  localparam int CW = $clog2(DW + 1);
  localparam logic signed [63:0] HALF    = 64'sd1 <<< (FRACTION_BITS - 1);
  localparam logic signed [63:0] Q_MAX64 = 64'sd2147483647;
  localparam logic signed [63:0] Q_MIN64 = -64'sd2147483648;
  localparam logic signed [VW-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VW-1:0] Q_MIN = 32'sh8000_0000;
  localparam logic [DW-1:0] POS_LIM = DW'(64'h7FFF_FFFF);
  localparam logic [DW-1:0] NEG_LIM = DW'(64'h8000_0000);

  logic        [slts_pkg::ROW_W-1:0] row_q;
  logic signed [VW-1:0]              coef_q;
  logic                              col_ok;
  logic signed [VW-1:0]              acc;
  logic                              sat;
  logic signed [63:0]                prod;
  logic signed [VW-1:0]              scaled;
  logic        [VW-1:0]              rem;
  logic        [VW-1:0]              dsr;
  logic        [DW-1:0]              dvd;
  logic        [DW-1:0]              quo;
  logic        [CW-1:0]              cnt;
  logic                              neg;
  logic                              zdiag;
  logic signed [VW-1:0]              sol;

  logic [31:0]          col_ext;
  logic [31:0]          row_ext;
  logic                 row_ok;
  logic [VW-1:0]        rdata;
  logic signed [VW-1:0] mul_op;
  logic signed [63:0]   rnd;
  logic signed [63:0]   shr;
  logic signed [VW-1:0] scaled_next;
  logic                 scale_sat;
  logic signed [VW:0]   diff;
  logic signed [VW-1:0] acc_sub;
  logic                 sub_sat;
  logic [VW-1:0]        acc_mag;
  logic [VW-1:0]        coef_mag;
  logic [VW:0]          trial;
  logic                 ge;
  logic signed [VW-1:0] sol_next;
  logic                 div_sat;

  assign col_ext = 32'(column);
  assign row_ext = 32'(row_q);
  assign row_ok  = row_ext < 32'(MAX_ROWS);

  slts_ram #(.WIDTH(VW), .DEPTH(MAX_ROWS)) u_store (
    .clk   (clk),
    .we    (cmd.emit && row_ok),
    .waddr (row_ext[AW-1:0]),
    .wdata (sol),
    .raddr (col_ext[AW-1:0]),
    .rdata (rdata)
  );

  assign status.last     = last_of_row;
  assign status.div_last = (cnt == CW'(1));
  assign status.out_busy = out_valid && !out_ready;

  assign mul_op = col_ok ? $signed(rdata) : '0;

  always_comb begin
    rnd         = prod + HALF;
    shr         = rnd >>> FRACTION_BITS;
    scaled_next = shr[VW-1:0];
    scale_sat   = 1'b0;
    if (shr > Q_MAX64) begin
      scaled_next = Q_MAX;
      scale_sat   = 1'b1;
    end else if (shr < Q_MIN64) begin
      scaled_next = Q_MIN;
      scale_sat   = 1'b1;
    end
  end

  always_comb begin
    diff    = {acc[VW-1], acc} - {scaled[VW-1], scaled};
    acc_sub = diff[VW-1:0];
    sub_sat = 1'b0;
    if (diff[VW] != diff[VW-1]) begin
      acc_sub = diff[VW] ? Q_MIN : Q_MAX;
      sub_sat = 1'b1;
    end
  end

  assign acc_mag  = acc[VW-1] ? VW'(-acc) : VW'(acc);
  assign coef_mag = coef_q[VW-1] ? VW'(-coef_q) : VW'(coef_q);
  assign trial    = {rem, dvd[DW-1]};
  assign ge       = trial >= {1'b0, dsr};

  always_comb begin
    sol_next = '0;
    div_sat  = 1'b0;
    if (!zdiag) begin
      if (neg) begin
        if (quo > NEG_LIM) begin
          sol_next = Q_MIN;
          div_sat  = 1'b1;
        end else begin
          sol_next = VW'(-quo[VW-1:0]);
        end
      end else begin
        if (quo > POS_LIM) begin
          sol_next = Q_MAX;
          div_sat  = 1'b1;
        end else begin
          sol_next = quo[VW-1:0];
        end
      end
    end
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      sat       <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load && first_of_row) begin
        acc <= right_side;
        sat <= 1'b0;
      end
      if (cmd.scale && scale_sat) begin
        sat <= 1'b1;
      end
      if (cmd.sub) begin
        acc <= acc_sub;
        if (sub_sat) begin
          sat <= 1'b1;
        end
      end
      if (cmd.div_init) begin
        cnt <= CW'(DW);
      end else if (cmd.div_step) begin
        cnt <= cnt - CW'(1);
      end
      if (cmd.div_fin && div_sat) begin
        sat <= 1'b1;
      end
      if (cmd.emit) begin
        acc <= '0;
        sat <= 1'b0;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      row_q  <= row;
      coef_q <= coefficient;
      col_ok <= col_ext < 32'(MAX_ROWS);
    end
    if (cmd.mul) begin
      prod <= 64'(coef_q) * 64'(mul_op);
    end
    if (cmd.scale) begin
      scaled <= scaled_next;
    end
    if (cmd.div_init) begin
      dvd   <= {acc_mag, {FRACTION_BITS{1'b0}}};
      dsr   <= coef_mag;
      rem   <= '0;
      quo   <= '0;
      neg   <= acc[VW-1] ^ coef_q[VW-1];
      zdiag <= (coef_q == '0);
    end
    if (cmd.div_step) begin
      rem <= ge ? VW'(trial - {1'b0, dsr}) : trial[VW-1:0];
      dvd <= {dvd[DW-2:0], 1'b0};
      quo <= {quo[DW-2:0], ge};
    end
    if (cmd.div_fin) begin
      sol <= sol_next;
    end
    if (cmd.emit) begin
      solved_row    <= row_q;
      solution      <= sol;
      zero_diagonal <= zdiag;
      saturated     <= sat;
    end
  end

endmodule
